[rtl/core/wxsh_pkg.sv]
// Package for the word xor-shift string hash core.
// Holds the queue entry type, register map constants and the fold and mask helpers.
// No dependencies.
`default_nettype none

package wxsh_pkg;

   localparam int DATA_W      = 32;
   localparam int BITS_W      = 6;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BITS_W-1:0]     INDEX_BITS_RESET = 6'd10;
   localparam logic [CSR_ADDR_W-1:0] REG_INDEX_BITS   = 3'd0;

   // One fold request for the back end: a word to add, and whether the key closes.
   typedef struct packed {
      logic [DATA_W-1:0] word;
      logic              key_end;
   } entry_type;

   function automatic logic [DATA_W-1:0] fold_word(input logic [DATA_W-1:0] v);
      fold_word = v ^ (v >> 3);
   endfunction

   // Widths of 32 and up select the full word.
   function automatic logic [DATA_W-1:0] table_mask(input logic [BITS_W-1:0] bits);
      if (bits[BITS_W-1]) begin
         table_mask = '1;
      end else begin
         table_mask = ~({DATA_W{1'b1}} << bits[BITS_W-2:0]);
      end
   endfunction

endpackage

`default_nettype wire

[rtl/core/wxsh_front.sv]
// Front end of the hash core: packs request bytes into big-endian words.
// Emits a fold request on a full word, a segment end or a key end. Uses wxsh_pkg.
`default_nettype none

module wxsh_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_byte_valid,
   input  wire logic                  req_segment_end,
   input  wire logic                  req_key_end,
   input  wire logic                  q_full,
   output logic                       q_push,
   output wxsh_pkg::entry_type        q_entry
);
   import wxsh_pkg::*;

   logic [DATA_W-1:0] word_ff, word_in;
   logic [1:0]        count_ff, count_in;
   logic [DATA_W-1:0] appended;
   logic              accept;
   logic              word_full;
   logic              seg_close;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      appended  = req_byte_valid ? {word_ff[DATA_W-9:0], req_data_byte} : word_ff;
      word_full = req_byte_valid && (count_ff == 2'd3);
      seg_close = req_segment_end || req_key_end;
      word_in   = word_ff;
      count_in  = count_ff;
      if (accept) begin
         if (word_full || seg_close) begin
            word_in  = '0;
            count_in = 2'd0;
         end else begin
            word_in  = appended;
            count_in = count_ff + {1'b0, req_byte_valid};
         end
      end
   end

   // A word completed together with a segment end leaves an empty tail: one fold covers both.
   assign q_push          = accept && (word_full || seg_close);
   assign q_entry.word    = appended;
   assign q_entry.key_end = req_key_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= '0;
         count_ff <= 2'd0;
      end else begin
         word_ff  <= word_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/wxsh_queue.sv]
// Short fold request queue between front and back end of the hash core.
// Register-based FIFO of QUEUE_DEPTH entries. Uses wxsh_pkg.
`default_nettype none

module wxsh_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire wxsh_pkg::entry_type   push_entry,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output wxsh_pkg::entry_type        head_entry
);
   import wxsh_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/core/wxsh_back.sv]
// Back end of the hash core: accumulates folded words and mixes the sum at key end.
// Stages: accumulate, mix partial sums, final add and mask into the result register.
// Uses wxsh_pkg.
`default_nettype none

module wxsh_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire wxsh_pkg::entry_type           head_entry,
   output logic                               pop,
   input  wire logic [wxsh_pkg::BITS_W-1:0]   index_bits,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [wxsh_pkg::DATA_W-1:0]        rsp_bucket_index
);
   import wxsh_pkg::*;

   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] sum;
   logic              hash_v_ff;
   logic [DATA_W-1:0] hash_ff;
   logic              mix_v_ff;
   logic [DATA_W-1:0] mix_lo_ff, mix_hi_ff;
   logic              out_v_ff;
   logic [DATA_W-1:0] out_ff;
   logic              out_free, mix_free, hash_free;

   assign out_free  = !out_v_ff || !rsp_stall;
   assign mix_free  = !mix_v_ff || out_free;
   assign hash_free = !hash_v_ff || mix_free;

   // Hold a key end in the queue until the hash stage has room.
   assign pop = head_valid && (!head_entry.key_end || hash_free);
   assign sum = acc_ff + fold_word(head_entry.word);

   always_comb begin
      acc_in = acc_ff;
      if (pop) begin
         acc_in = head_entry.key_end ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         hash_v_ff <= 1'b0;
         mix_v_ff  <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         if (hash_free) begin
            hash_v_ff <= pop && head_entry.key_end;
         end
         if (mix_free) begin
            mix_v_ff <= hash_v_ff;
         end
         if (out_free) begin
            out_v_ff <= mix_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hash_free) begin
         hash_ff <= sum;
      end
      if (mix_free) begin
         mix_lo_ff <= hash_ff + (hash_ff >> 11);
         mix_hi_ff <= (hash_ff >> 13) + (hash_ff >> 23);
      end
      if (out_free) begin
         out_ff <= (mix_lo_ff + mix_hi_ff) & table_mask(index_bits);
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_bucket_index = out_ff;

endmodule

`default_nettype wire

[rtl/core/word_xor_shift_string_hash_core.sv]
// A key end request passes the queue, then the accumulate, mix, and final add and mask
// registers, in that order, before it raises rsp_valid.
// Throughput: one request per cycle while req_stall is low; the two-entry queue lets
// the front keep taking bytes while the result register waits on rsp_stall.
// Reset: synchronous, clears byte packing, accumulator, queue and pipeline valids;
// index_bits returns to 10.
`default_nettype none

module word_xor_shift_string_hash_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [7:0]                            req_data_byte,
   input  wire logic                                  req_byte_valid,
   input  wire logic                                  req_segment_end,
   input  wire logic                                  req_key_end,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [wxsh_pkg::DATA_W-1:0]                rsp_bucket_index,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [wxsh_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [wxsh_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [wxsh_pkg::CSR_DATA_W-1:0]            prdata,
   output logic                                       pready
);
   import wxsh_pkg::*;

   logic [BITS_W-1:0] index_bits_ff;
   logic              q_full;
   logic              q_push;
   entry_type         q_in_entry;
   logic              q_pop;
   logic              q_head_valid;
   entry_type         q_head_entry;

   assign pready = 1'b1;
   assign prdata = (paddr == REG_INDEX_BITS) ? CSR_DATA_W'(index_bits_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= INDEX_BITS_RESET;
      end else if (psel && penable && pwrite && pready && (paddr == REG_INDEX_BITS)) begin
         index_bits_ff <= pwdata[BITS_W-1:0];
      end
   end

   wxsh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_segment_end (req_segment_end),
      .req_key_end     (req_key_end),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_in_entry)
   );

   wxsh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   wxsh_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_head_valid),
      .head_entry       (q_head_entry),
      .pop              (q_pop),
      .index_bits       (index_bits_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule

`default_nettype wire

[rtl/core/wxsh_checker.sv]
// Port-level checks for the hash core, bound to word_xor_shift_string_hash_core.
// Mirrors the table size register from CSR writes. Uses wxsh_pkg.
`default_nettype none

module wxsh_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire logic [wxsh_pkg::DATA_W-1:0]           rsp_bucket_index,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [wxsh_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [wxsh_pkg::CSR_DATA_W-1:0]       pwdata,
   input  wire logic [wxsh_pkg::CSR_DATA_W-1:0]       prdata
);
   import wxsh_pkg::*;

   logic [BITS_W-1:0] bits_ff;
   logic              csr_write;

   assign csr_write = psel && penable && pwrite && (paddr == REG_INDEX_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= INDEX_BITS_RESET;
      end else if (csr_write) begin
         bits_ff <= pwdata[BITS_W-1:0];
      end
   end

   // Result stays put while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bucket_index))
      else $error("result changed while stalled");

   // Result never has bits above the table size.
   a_rsp_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_bucket_index & ~table_mask(bits_ff)) == '0))
      else $error("bucket index exceeds table size");

   // No result right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Register read-back follows the last write.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (paddr != REG_INDEX_BITS) ||
                    (prdata == CSR_DATA_W'($past(pwdata[BITS_W-1:0]))))
      else $error("index_bits read-back mismatch");

endmodule

bind word_xor_shift_string_hash_core wxsh_checker u_wxsh_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_bucket_index (rsp_bucket_index),
   .psel             (psel),
   .penable          (penable),
   .pwrite           (pwrite),
   .paddr            (paddr),
   .pwdata           (pwdata),
   .prdata           (prdata)
);

`default_nettype wire
